/* hdl/block_buffer_cache_lru_defines.svh */
// ----------------------------------------------------------------------------
// Buffer cache assertion macros
// Shared concurrent assertion forms for the buffer cache RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH
`define BLOCK_BUFFER_CACHE_LRU_DEFINES_SVH

// same-cycle implication
`define BBC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define BBC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/bbc_pkg.sv */
// ----------------------------------------------------------------------------
// Buffer cache package
// Mode codes, update commands and the word carried down the cell chain.
// ----------------------------------------------------------------------------
package bbc_pkg;

   localparam int IDX_W = 8;

   localparam logic [2:0] MODE_GET     = 3'd0;
   localparam logic [2:0] MODE_MARK    = 3'd1;
   localparam logic [2:0] MODE_RELEASE = 3'd2;
   localparam logic [2:0] MODE_PIN     = 3'd3;
   localparam logic [2:0] MODE_UNPIN   = 3'd4;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   localparam logic [7:0] COUNT_MAX = 8'd255;

   typedef enum logic [2:0] {
      CMD_NONE  = 3'd0,
      CMD_RETAG = 3'd1,
      CMD_INC   = 3'd2,
      CMD_DEC   = 3'd3,
      CMD_MARK  = 3'd4
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type        op;
      logic [IDX_W-1:0]  idx;
      logic              stamp;
      logic [15:0]       device;
      logic [31:0]       block;
      logic [31:0]       now;
   } commit_type;

   typedef struct packed {
      logic              valid;
      logic [2:0]        mode;
      logic [15:0]       device;
      logic [31:0]       block;
      logic [4:0]        slot;
      logic [31:0]       now;
      logic              match_found;
      logic [IDX_W-1:0]  match_idx;
      logic              match_valid;
      logic              free_found;
      logic [IDX_W-1:0]  pick_idx;
      logic [31:0]       pick_time;
      logic [7:0]        addr_count;
      logic              addr_valid;
   } token_type;

endpackage

/* hdl/bbc_cell.sv */
// ----------------------------------------------------------------------------
// Buffer cache cell
// Holds one slot; folds its tags, count and time into the passing word and
// applies the update command addressed to it.
// ----------------------------------------------------------------------------
module bbc_cell import bbc_pkg::*; #(
   parameter int unsigned IDX = 0
) (
   input  logic       clock,
   input  logic       reset,
   input  token_type  tok_in,
   input  commit_type commit,
   output token_type  tok_out
);

   logic [15:0] dev_ff,   dev_in;
   logic [31:0] blk_ff,   blk_in;
   logic [7:0]  cnt_ff,   cnt_in;
   logic [31:0] time_ff,  time_in;
   logic        valid_ff, valid_in;
   token_type   tok_ff,   tok_nx_in;
   logic        sel;

   always_comb begin
      tok_nx_in = tok_in;
      if (tok_in.valid) begin
         if (!tok_in.match_found && dev_ff == tok_in.device && blk_ff == tok_in.block) begin
            tok_nx_in.match_found = 1'b1;
            tok_nx_in.match_idx   = IDX_W'(IDX);
            tok_nx_in.match_valid = valid_ff;
         end
         if (cnt_ff == 8'd0 && (!tok_in.free_found || time_ff < tok_in.pick_time)) begin
            tok_nx_in.free_found = 1'b1;
            tok_nx_in.pick_idx   = IDX_W'(IDX);
            tok_nx_in.pick_time  = time_ff;
         end
         if (32'(tok_in.slot) == 32'(IDX)) begin
            tok_nx_in.addr_count = cnt_ff;
            tok_nx_in.addr_valid = valid_ff;
         end
      end
   end

   assign sel = (commit.idx == IDX_W'(IDX));

   always_comb begin
      dev_in   = dev_ff;
      blk_in   = blk_ff;
      cnt_in   = cnt_ff;
      time_in  = time_ff;
      valid_in = valid_ff;
      if (sel) begin
         case (commit.op)
            CMD_RETAG: begin
               dev_in   = commit.device;
               blk_in   = commit.block;
               cnt_in   = 8'd1;
               valid_in = 1'b0;
            end
            CMD_INC: begin
               if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + 8'd1;
            end
            CMD_DEC: begin
               cnt_in = cnt_ff - 8'd1;
               if (commit.stamp) time_in = commit.now;
            end
            CMD_MARK: valid_in = 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_ff       <= '0;
         blk_ff       <= '0;
         cnt_ff       <= '0;
         time_ff      <= '0;
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         dev_ff   <= dev_in;
         blk_ff   <= blk_in;
         cnt_ff   <= cnt_in;
         time_ff  <= time_in;
         valid_ff <= valid_in;
         tok_ff   <= tok_nx_in;
      end
   end

   assign tok_out = tok_ff;

endmodule

/* hdl/block_buffer_cache_lru.sv */
// Flow: a request is captured at accept, walks the cell chain one cell per
// cycle into done_ff, and the chosen slot is updated as the response loads.
// A new request is accepted only in idle, after the last response is loaded.
// Reset: synchronous; all slots clear to tags 0, count 0, time 0, not valid.
// A response may wait while the next request is accepted.
// ----------------------------------------------------------------------------
// Buffer cache with LRU replacement
// Top level: request capture, cell chain, decision and response register.
// ----------------------------------------------------------------------------
`include "block_buffer_cache_lru_defines.svh"

module block_buffer_cache_lru import bbc_pkg::*; #(
   parameter int BUFFERS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_slot,
   input  logic [31:0] req_now,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [4:0]  rsp_slot_out,
   output logic        rsp_hit,
   output logic        rsp_contents_valid,
   output logic [1:0]  rsp_status
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type   state_ff, state_in;
   token_type   start_ff, start_in;
   token_type   done_ff,  done_in;
   token_type   chain [BUFFERS+1];
   commit_type  commit;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [4:0]  slot_ff, slot_in;
   logic        hit_ff, hit_in;
   logic        cv_ff, cv_in;
   logic [1:0]  status_ff, status_in;
   logic        accept, rsp_load;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   assign chain[0] = start_ff;

   for (genvar g = 0; g < BUFFERS; g++) begin : g_cell
      bbc_cell #(.IDX(g)) u_cell (
         .clock  (clock),
         .reset  (reset),
         .tok_in (chain[g]),
         .commit (commit),
         .tok_out(chain[g+1])
      );
   end

   always_comb begin
      start_in             = '0;
      start_in.valid       = accept;
      start_in.mode        = req_mode;
      start_in.device      = req_device;
      start_in.block       = req_block_number;
      start_in.slot        = req_slot;
      start_in.now         = req_now;
      done_in              = chain[BUFFERS].valid ? chain[BUFFERS] : done_ff;
   end

   always_comb begin
      commit        = '0;
      commit.op     = CMD_NONE;
      commit.idx    = IDX_W'(done_ff.slot);
      commit.device = done_ff.device;
      commit.block  = done_ff.block;
      commit.now    = done_ff.now;
      slot_in       = done_ff.slot;
      hit_in        = 1'b0;
      cv_in         = 1'b0;
      status_in     = STATUS_OK;
      if (done_ff.mode == MODE_GET) begin
         if (done_ff.match_found) begin
            commit.op  = CMD_INC;
            commit.idx = done_ff.match_idx;
            slot_in    = done_ff.match_idx[4:0];
            hit_in     = 1'b1;
            cv_in      = done_ff.match_valid;
         end else if (done_ff.free_found) begin
            commit.op  = CMD_RETAG;
            commit.idx = done_ff.pick_idx;
            slot_in    = done_ff.pick_idx[4:0];
         end else begin
            slot_in    = 5'd0;
            status_in  = STATUS_NO_FREE;
         end
      end else if (32'(done_ff.slot) < 32'(BUFFERS)) begin
         cv_in = done_ff.addr_valid;
         case (done_ff.mode)
            MODE_MARK: begin
               commit.op = CMD_MARK;
               cv_in     = 1'b1;
            end
            MODE_RELEASE, MODE_UNPIN: begin
               if (done_ff.addr_count == 8'd0) begin
                  status_in = STATUS_UNDERFLOW;
               end else begin
                  commit.op    = CMD_DEC;
                  commit.stamp = (done_ff.mode == MODE_RELEASE) &&
                                 (done_ff.addr_count == 8'd1);
               end
            end
            MODE_PIN: commit.op = CMD_INC;
            default: cv_in = 1'b0;
         endcase
      end
      if (!rsp_load) commit.op = CMD_NONE;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SCAN;
         ST_SCAN: if (chain[BUFFERS].valid) state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;
      if (rsp_load) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         start_ff.valid <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         start_ff     <= start_in;
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= done_in;
      if (rsp_load) begin
         slot_ff   <= slot_in;
         hit_ff    <= hit_in;
         cv_ff     <= cv_in;
         status_ff <= status_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_slot_out       = slot_ff;
   assign rsp_hit            = hit_ff;
   assign rsp_contents_valid = cv_ff;
   assign rsp_status         = status_ff;

   `BBC_ASSERT_NOW(a_chain_out_in_scan, clock, reset, chain[BUFFERS].valid, state_ff == ST_SCAN, "chain word outside scan")
   `BBC_ASSERT_NEXT(a_accept_starts_scan, clock, reset, accept, state_ff == ST_SCAN && start_ff.valid, "accept did not start scan")
   `BBC_ASSERT_NOW(a_commit_in_done, clock, reset, commit.op != CMD_NONE, state_ff == ST_DONE && rsp_load, "update outside decision")
   `BBC_ASSERT_NEXT(a_load_sets_rsp, clock, reset, rsp_load, rsp_valid_ff, "response not loaded")

endmodule

/* tb/sv/block_buffer_cache_lru_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache response checker
// Watches the request and response channels, keeps a shadow copy of the
// slot tags, counts and times, predicts each response and compares it.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_checker import bbc_pkg::*; #(
   parameter int BUFFERS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [15:0] req_device,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_slot,
   input  logic [31:0] req_now,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [4:0]  rsp_slot_out,
   input  logic        rsp_hit,
   input  logic        rsp_contents_valid,
   input  logic [1:0]  rsp_status,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [4:0] slot_out;
      logic       hit;
      logic       contents_valid;
      logic [1:0] status;
   } lookup_type;

   logic [15:0] shadow_device [BUFFERS];
   logic [31:0] shadow_block [BUFFERS];
   logic [7:0]  shadow_count [BUFFERS];
   logic [31:0] shadow_time [BUFFERS];
   logic        shadow_valid [BUFFERS];
   lookup_type  expected_words [$];

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic lookup_type cache_access(input logic [2:0] mode,
      input logic [15:0] dev, input logic [31:0] blk, input logic [4:0] s,
      input logic [31:0] stamp);
      lookup_type w;
      int pick;
      w = '0;
      w.slot_out = s;
      if (mode == MODE_GET) begin
         for (int i = 0; i < BUFFERS; i++)
            if (shadow_device[i] == dev && shadow_block[i] == blk) begin
               if (shadow_count[i] != COUNT_MAX) shadow_count[i]++;
               w.slot_out = 5'(i);
               w.hit = 1'b1;
               w.contents_valid = shadow_valid[i];
               return w;
            end
         pick = -1;
         for (int i = 0; i < BUFFERS; i++)
            if (shadow_count[i] == 0 && (pick < 0 || shadow_time[i] < shadow_time[pick]))
               pick = i;
         if (pick < 0) begin
            w.slot_out = '0;
            w.status = STATUS_NO_FREE;
            return w;
         end
         shadow_device[pick] = dev;
         shadow_block[pick] = blk;
         shadow_count[pick] = 8'd1;
         shadow_valid[pick] = 1'b0;
         w.slot_out = 5'(pick);
         return w;
      end
      if (mode > MODE_UNPIN || s >= BUFFERS) return w;
      case (mode)
         MODE_MARK: shadow_valid[s] = 1'b1;
         MODE_RELEASE: begin
            if (shadow_count[s] == 0) w.status = STATUS_UNDERFLOW;
            else begin
               shadow_count[s]--;
               if (shadow_count[s] == 0) shadow_time[s] = stamp;
            end
         end
         MODE_PIN: if (shadow_count[s] != COUNT_MAX) shadow_count[s]++;
         default: begin
            if (shadow_count[s] == 0) w.status = STATUS_UNDERFLOW;
            else shadow_count[s]--;
         end
      endcase
      w.contents_valid = shadow_valid[s];
      return w;
   endfunction

   initial begin
      errors = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      lookup_type want;
      if (reset) begin
         for (int i = 0; i < BUFFERS; i++) begin
            shadow_device[i] = '0;
            shadow_block[i] = '0;
            shadow_count[i] = '0;
            shadow_time[i] = '0;
            shadow_valid[i] = 1'b0;
         end
         expected_words.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_words.size() == 0) begin
               $display("unexpected response word at %0t", $realtime);
               errors++;
            end else begin
               want = expected_words.pop_front();
               if (rsp_slot_out !== want.slot_out)
                  report("slot_out", rsp_slot_out, want.slot_out);
               if (rsp_hit !== want.hit) report("hit", rsp_hit, want.hit);
               if (rsp_contents_valid !== want.contents_valid)
                  report("contents_valid", rsp_contents_valid, want.contents_valid);
               if (rsp_status !== want.status) report("status", rsp_status, want.status);
            end
         end
         if (req_valid && req_ready)
            expected_words.push_back(cache_access(req_mode, req_device,
               req_block_number, req_slot, req_now));
      end
      pending = expected_words.size();
   end

endmodule

/* tb/sv/block_buffer_cache_lru_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer cache testbench
// Directed corner words, then random traffic over a small tag set so gets
// hit, evict and run out of free slots, under varying idle and stall phases.
// ----------------------------------------------------------------------------
module block_buffer_cache_lru_test;
   import bbc_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_mode = '0;
   logic [15:0] req_device = '0;
   logic [31:0] req_block_number = '0;
   logic [4:0]  req_slot = '0;
   logic [31:0] req_now = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [4:0]  rsp_slot_out;
   logic        rsp_hit;
   logic        rsp_contents_valid;
   logic [1:0]  rsp_status;
   int          errors;
   int          pending;
   int          send_idle = 0;
   int          recv_stall = 0;
   int          hold_off = 0;
   logic [31:0] tick = 32'd1;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   block_buffer_cache_lru dut (.*);
   block_buffer_cache_lru_checker checker_i (.*);

   always @(negedge clock) begin
      if (hold_off > 0) begin
         rsp_ready <= 1'b0;
         hold_off <= hold_off - 1;
      end else rsp_ready <= ($urandom_range(99) >= recv_stall);
   end

   // valid stays up after an accept until the next word or an idle cycle
   task automatic send_word(input logic [2:0] mode, input logic [15:0] dev,
      input logic [31:0] blk, input logic [4:0] s, input logic [31:0] stamp);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_device <= dev;
      req_block_number <= blk;
      req_slot <= s;
      req_now <= stamp;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic random_word();
      logic [2:0] mode;
      int r;
      r = $urandom_range(99);
      tick = tick + $urandom_range(3);
      if (r < 4) begin
         send_word(3'($urandom), 16'($urandom), $urandom, 5'($urandom), $urandom);
         return;
      end
      mode = (r < 45) ? MODE_GET : (r < 55) ? MODE_MARK : (r < 80) ? MODE_RELEASE :
             (r < 90) ? MODE_PIN : MODE_UNPIN;
      send_word(mode, 16'($urandom_range(3)), $urandom_range(40), 5'($urandom_range(31)),
                ($urandom_range(19) == 0) ? $urandom : tick);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_word(MODE_GET, 16'd0, 32'd0, 5'd0, 32'd0);
      send_word(MODE_GET, 16'hFFFF, 32'hFFFF_FFFF, 5'd0, 32'd0);
      send_word(MODE_MARK, 16'd0, 32'd0, 5'd1, 32'd0);
      send_word(MODE_RELEASE, 16'd0, 32'd0, 5'd1, 32'hFFFF_FFFF);
      send_word(MODE_RELEASE, 16'd0, 32'd0, 5'd1, 32'd5);
      send_word(MODE_UNPIN, 16'd0, 32'd0, 5'd2, 32'd0);
      send_word(MODE_PIN, 16'd0, 32'd0, 5'd31, 32'd0);
      send_word(MODE_UNPIN, 16'd0, 32'd0, 5'd31, 32'd0);
      send_word(3'd5, 16'h1234, 32'd9, 5'd7, 32'd0);
      send_word(3'd7, 16'h0, 32'd0, 5'd31, 32'd0);
      for (int i = 0; i < 20; i++) send_word(MODE_GET, 16'd1, 32'(i), 5'd0, 32'd0);
      send_word(MODE_GET, 16'd2, 32'd0, 5'd0, 32'd0);
      for (int i = 0; i < 260; i++) send_word(MODE_PIN, 16'd0, 32'd0, 5'd3, 32'd0);
      send_word(MODE_GET, 16'd1, 32'd5, 5'd0, 32'd0);
      drain();
      for (int phase = 0; phase < 4; phase++) begin
         send_idle = (phase == 1 || phase == 3) ? 68 : (phase == 3 ? 24 : 0);
         recv_stall = (phase == 2) ? 68 : 0;
         if (phase == 3) begin
            send_idle = 24;
            recv_stall = 24;
         end
         if (phase == 2) hold_off = 400;
         for (int i = 0; i < 250; i++) random_word();
         drain();
      end
      send_idle = 0;
      recv_stall = 0;
      for (int i = 0; i < 200; i++) random_word();
      drain();
      if (errors == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

   initial begin
      #20ms;
      $display("Test completed with failures");
      $finish;
   end

endmodule
